[hdl/sfd_pkg.sv]
// Shared constants and types for the SBUS frame decoder.
package sfd_pkg;

    localparam int FRAME_BYTES    = 25;
    localparam int STORE_CELLS    = FRAME_BYTES - 1;
    localparam int NUM_CHANNELS   = 16;
    localparam int CHANNEL_BITS   = 11;
    localparam int CHAN_BYTES     = 22;
    localparam int CHAN_DATA_BITS = CHAN_BYTES * 8;
    localparam int FLAGS_BYTE     = 23;
    localparam int FAILSAFE_BIT   = 3;
    localparam int LOST_BIT       = 2;
    localparam int COUNT_W        = $clog2(FRAME_BYTES);
    localparam int INDEX_W        = $clog2(NUM_CHANNELS);

    localparam logic [COUNT_W-1:0] LAST_COUNT    = COUNT_W'(FRAME_BYTES - 1);
    localparam logic [INDEX_W-1:0] LAST_CHANNEL  = INDEX_W'(NUM_CHANNELS - 1);
    localparam logic [7:0]         HEADER_RESET  = 8'h0F;
    localparam logic [7:0]         FOOTER_RESET  = 8'h00;

    // Register decode on the word address bit
    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_FOOTER = 1'b1;

    // Finished frame handed from the byte chain to the emitter
    typedef struct packed {
        logic                      ok;
        logic                      failsafe;
        logic                      lost;
        logic [CHAN_DATA_BITS-1:0] chan_bits;
    } sfd_frame_t;

endpackage

[hdl/sbus_frame_decoder_core.sv]
// Top level of the SBUS frame decoder: byte chain, frame check, registers.
//
//  channel  | direction | handshake        | payload
//  s_       | in        | s_valid/s_ready  | s_rx_byte[7:0]
//  m_       | out       | m_valid/m_ready  | index, value, failsafe, frame_lost, frame_ok, last
//  APB      | in        | psel/penable     | paddr[2:0], pwdata/prdata[31:0]
//
// One byte is accepted per cycle; each kept byte but the last of a frame shifts into
// a chain of 24 cells, and idle non-header bytes are dropped without a shift.
// The 25th byte closes the frame at its accepting edge; from the next cycle the emitter
// gives 16 results (or one for a bad frame) at one per cycle while m_ready holds, shifting
// its channel register down by 11 bits per result taken.
// The byte chain keeps accepting while results drain; only a frame's final byte waits
// until the emitter has handed out the last result of the previous frame.
// Reset (aresetn low, synchronous) clears the byte count, the emitter and the registers.
module sbus_frame_decoder_core
    import sfd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [INDEX_W-1:0]      m_channel_index,
    output logic [CHANNEL_BITS-1:0] m_channel_value,
    output logic                    m_failsafe,
    output logic                    m_frame_lost,
    output logic                    m_frame_ok,
    output logic                    m_last,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [7:0]         header_reg, header_next;
    logic [7:0]         footer_reg, footer_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         cell_q [STORE_CELLS];
    logic               accept, drop, final_byte, shift_en, load, can_load;
    sfd_frame_t         frame;

    // Register port: always ready, write on the access phase
    assign pready = 1'b1;

    always_comb begin
        header_next = header_reg;
        footer_next = footer_reg;
        if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_HEADER: header_next = pwdata[7:0];
                REG_FOOTER: footer_next = pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_HEADER: prdata = {24'd0, header_reg};
            REG_FOOTER: prdata = {24'd0, footer_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            footer_reg <= FOOTER_RESET;
        end else begin
            header_reg <= header_next;
            footer_reg <= footer_next;
        end
    end

    // Hold the closing byte until the emitter can take a new frame
    assign final_byte = (count_reg == LAST_COUNT);
    assign s_ready    = !final_byte || can_load;
    assign accept     = s_valid && s_ready;
    assign drop       = (count_reg == '0) && (s_rx_byte != header_reg);
    assign shift_en   = accept && !drop && !final_byte;
    assign load       = accept && final_byte;

    // Count collected bytes; drop idle non-header bytes
    always_comb begin
        count_next = count_reg;
        if (accept && !drop) begin
            count_next = final_byte ? '0 : count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Byte chain: new bytes enter the top cell and move down one cell per byte
    for (genvar i = 0; i < STORE_CELLS; i++) begin : g_cell
        logic [7:0] d_in;
        if (i == STORE_CELLS - 1) begin : g_top
            assign d_in = s_rx_byte;
        end else begin : g_mid
            assign d_in = cell_q[i+1];
        end
        sfd_byte_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .d_in     (d_in),
            .q        (cell_q[i])
        );
    end

    // Gather channel bytes little-endian and check header and footer
    for (genvar b = 0; b < CHAN_BYTES; b++) begin : g_pack
        assign frame.chan_bits[8*b +: 8] = cell_q[b+1];
    end

    assign frame.ok       = (cell_q[0] == header_reg) && (s_rx_byte == footer_reg);
    assign frame.failsafe = cell_q[FLAGS_BYTE][FAILSAFE_BIT];
    assign frame.lost     = cell_q[FLAGS_BYTE][LOST_BIT];

    sfd_emitter u_emitter (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .frame           (frame),
        .can_load        (can_load),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_failsafe      (m_failsafe),
        .m_frame_lost    (m_frame_lost),
        .m_frame_ok      (m_frame_ok),
        .m_last          (m_last)
    );

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_COUNT)
        else $error("byte count beyond frame length");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (final_byte && m_valid))
        else $error("input stalled without a pending closing byte");

    a_idle_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && drop) |=> (count_reg == '0 && !$past(load)))
        else $error("dropped byte moved the frame count");

endmodule

[hdl/sfd_byte_cell.sv]
// One byte cell of the frame chain: loads its neighbor's byte on a shift.
module sfd_byte_cell
    import sfd_pkg::*;
(
    input  logic       aclk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    output logic [7:0] q
);

    logic [7:0] byte_reg;

    // Take the neighbor's byte on each shift, hold otherwise
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= d_in;
        end
    end

    assign q = byte_reg;

endmodule

[hdl/sfd_emitter.sv]
// Result emitter: shifts one 11-bit channel out per accepted result.
module sfd_emitter
    import sfd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  sfd_frame_t          frame,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [INDEX_W-1:0]  m_channel_index,
    output logic [CHANNEL_BITS-1:0] m_channel_value,
    output logic                m_failsafe,
    output logic                m_frame_lost,
    output logic                m_frame_ok,
    output logic                m_last
);

    logic                      busy_reg, busy_next;
    logic [INDEX_W-1:0]        idx_reg, idx_next;
    logic                      ok_reg, ok_next;
    logic                      fs_reg, fs_next;
    logic                      fl_reg, fl_next;
    logic [CHAN_DATA_BITS-1:0] bits_reg, bits_next;
    logic                      take;

    assign take     = busy_reg && m_ready;
    assign m_last   = !ok_reg || (idx_reg == LAST_CHANNEL);
    assign can_load = !busy_reg || (take && m_last);

    // Load a new frame, or advance to the next channel on each request taken
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        ok_next   = ok_reg;
        fs_next   = fs_reg;
        fl_next   = fl_reg;
        bits_next = bits_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = '0;
            ok_next   = frame.ok;
            fs_next   = frame.failsafe;
            fl_next   = frame.lost;
            bits_next = frame.chan_bits;
        end else if (take) begin
            if (m_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next  = idx_reg + INDEX_W'(1);
                bits_next = bits_reg >> CHANNEL_BITS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg   <= ok_next;
        fs_reg   <= fs_next;
        fl_reg   <= fl_next;
        bits_reg <= bits_next;
    end

    // Zero the channel value and the flags of a bad frame
    assign m_valid         = busy_reg;
    assign m_frame_ok      = ok_reg;
    assign m_channel_index = idx_reg;
    assign m_channel_value = ok_reg ? bits_reg[CHANNEL_BITS-1:0] : '0;
    assign m_failsafe      = ok_reg && fs_reg;
    assign m_frame_lost    = ok_reg && fl_reg;

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load)
        else $error("frame loaded while results still pending");

    a_bad_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_ok) |-> (m_last && m_channel_index == '0))
        else $error("bad frame result is not a single final result");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last && !load) |=>
            (m_valid && m_channel_index == $past(m_channel_index) + INDEX_W'(1)))
        else $error("channel run did not advance by one");

endmodule

[dv/tb_sbus_frame_decoder_core.sv]
// Testbench for the SBUS frame decoder: frame traffic, register changes and checked results.
`timescale 1ns / 1ps

module tb_sbus_frame_decoder_core;
    import sfd_pkg::*;

    localparam int ITEM_TARGET    = 410;
    localparam int QUIET_TAIL     = 160;
    localparam int SETTLE_CYCLES  = 24;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_PRINTS     = 20;

    typedef struct packed {
        logic [INDEX_W-1:0]      index;
        logic [CHANNEL_BITS-1:0] value;
        logic                    failsafe;
        logic                    lost;
        logic                    ok;
        logic                    last;
    } chan_result_t;

    typedef enum int {FRAME_GOOD, FRAME_BAD_FOOTER, FRAME_SHORT} frame_kind_t;

    // Tracks the decoder state and the channel results still owed by the block
    class frame_scoreboard;
        logic [7:0]   header;
        logic [7:0]   footer;
        logic [7:0]   frame_byte[FRAME_BYTES];
        int           byte_count;
        chan_result_t channel_q[$];
        int           errors;
        int           good_frames;
        int           bad_frames;
        int           checked;

        function new();
            header      = HEADER_RESET;
            footer      = FOOTER_RESET;
            byte_count  = 0;
            errors      = 0;
            good_frames = 0;
            bad_frames  = 0;
            checked     = 0;
        endfunction

        function void set_reg(logic sel, logic [7:0] val);
            if (sel == REG_HEADER) header = val;
            else footer = val;
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        // Advance the frame state by one accepted byte request
        function void note_byte(logic [7:0] b);
            chan_result_t            r;
            logic [CHAN_DATA_BITS-1:0] chan_bits;
            if (byte_count == 0 && b != header) return;
            frame_byte[byte_count] = b;
            byte_count++;
            if (byte_count < FRAME_BYTES) return;
            byte_count = 0;

            // Reject on header or footer mismatch: one zeroed, last-marked result
            if (frame_byte[0] != header || frame_byte[FRAME_BYTES-1] != footer) begin
                r = '0;
                r.last = 1'b1;
                channel_q.push_back(r);
                bad_frames++;
                return;
            end

            // Unpack 16 little-endian 11-bit channels from bytes 1 to 22
            for (int i = 0; i < CHAN_BYTES; i++) chan_bits[8*i +: 8] = frame_byte[i+1];
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r.index    = INDEX_W'(ch);
                r.value    = chan_bits[ch*CHANNEL_BITS +: CHANNEL_BITS];
                r.failsafe = frame_byte[FLAGS_BYTE][FAILSAFE_BIT];
                r.lost     = frame_byte[FLAGS_BYTE][LOST_BIT];
                r.ok       = 1'b1;
                r.last     = (ch == NUM_CHANNELS - 1);
                channel_q.push_back(r);
            end
            good_frames++;
        endfunction

        // Compare one result request against the oldest expectation
        function void check_result(chan_result_t got);
            chan_result_t want;
            if (channel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = channel_q.pop_front();
            checked++;
            if (got.index !== want.index)
                report_mismatch($sformatf("channel_index %0d, want %0d", got.index, want.index));
            if (got.value !== want.value)
                report_mismatch($sformatf("channel_value %0d, want %0d (channel %0d)",
                                          got.value, want.value, want.index));
            if (got.failsafe !== want.failsafe)
                report_mismatch($sformatf("failsafe %b, want %b", got.failsafe, want.failsafe));
            if (got.lost !== want.lost)
                report_mismatch($sformatf("frame_lost %b, want %b", got.lost, want.lost));
            if (got.ok !== want.ok)
                report_mismatch($sformatf("frame_ok %b, want %b", got.ok, want.ok));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [7:0]              s_rx_byte;
    logic                    m_valid;
    logic                    m_ready;
    logic [INDEX_W-1:0]      m_channel_index;
    logic [CHANNEL_BITS-1:0] m_channel_value;
    logic                    m_failsafe;
    logic                    m_frame_lost;
    logic                    m_frame_ok;
    logic                    m_last;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    frame_scoreboard book;
    int  bytes_sent;
    int  settings_used;
    int  gap_pct;
    int  stall_pct;
    int  stall_left;
    bit  hold_armed;
    int  cycle_cnt;

    sbus_frame_decoder_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_failsafe      (m_failsafe),
        .m_frame_lost    (m_frame_lost),
        .m_frame_ok      (m_frame_ok),
        .m_last          (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Hold off the result side in short random bursts, or for one long stretch on request
    always @(posedge aclk) begin
        if (hold_armed) begin
            hold_armed = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check every accepted result request
    always @(posedge aclk) begin : watch_results
        chan_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.index    = m_channel_index;
            seen.value    = m_channel_value;
            seen.failsafe = m_failsafe;
            seen.lost     = m_frame_lost;
            seen.ok       = m_frame_ok;
            seen.last     = m_last;
            book.check_result(seen);
        end
    end

    // End the run if it hangs
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one byte request, hold it until accepted, then maybe idle
    task automatic send_byte(input logic [7:0] b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        book.note_byte(b);
        bytes_sent++;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (book.channel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        book.set_reg(sel, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_check(input logic sel, input logic [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'h0, want})
            book.report_mismatch($sformatf("register %0d reads %h, want %h", sel, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame_regs(input logic [7:0] hdr, input logic [7:0] ftr);
        write_reg(REG_HEADER, hdr);
        write_reg(REG_FOOTER, ftr);
        read_check(REG_HEADER, hdr);
        read_check(REG_FOOTER, ftr);
        settings_used++;
    endtask

    // Leading noise that the idle decoder should drop
    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count) begin
            do b = 8'($urandom_range(0, 255)); while (b == book.header);
            send_byte(b);
        end
    endtask

    // Send one frame: well formed, with a wrong footer, or cut short
    task automatic send_frame(input frame_kind_t kind);
        int         len;
        logic [7:0] ftr;
        len = (kind == FRAME_SHORT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        ftr = book.footer;
        if (kind == FRAME_BAD_FOOTER) ftr = ftr ^ 8'($urandom_range(1, 255));
        send_byte(book.header);
        for (int i = 1; i < len; i++) begin
            if (i == FRAME_BYTES - 1) send_byte(ftr);
            else send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : main
        logic [7:0]  hdr;
        logic [7:0]  ftr;
        int          phase;
        int          pick;
        frame_kind_t kind;

        book          = new();
        bytes_sent    = 0;
        settings_used = 0;
        gap_pct       = 25;
        stall_pct     = 20;
        stall_left    = 0;
        hold_armed    = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'h00;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= 3'b000;
        pwdata    <= 32'h0;
        m_ready   <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values, idle drops at both byte extremes, then a frame with all channel bits set
        read_check(REG_HEADER, HEADER_RESET);
        read_check(REG_FOOTER, FOOTER_RESET);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(HEADER_RESET);
        repeat (CHAN_BYTES) send_byte(8'hFF);
        send_byte(8'h0C);
        send_byte(FOOTER_RESET);

        // Random phases, each under its own register setting
        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            settle();
            case (phase)
                0: begin hdr = 8'h00; ftr = 8'hFF; end
                1: begin hdr = 8'hFF; ftr = 8'h00; end
                default: begin
                    hdr = 8'($urandom_range(0, 255));
                    ftr = 8'($urandom_range(0, 255));
                end
            endcase
            set_frame_regs(hdr, ftr);

            if (bytes_sent >= ITEM_TARGET - QUIET_TAIL) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                pick      = $urandom_range(0, 2);
                gap_pct   = pick * 20;
                stall_pct = (pick == 1) ? 0 : 25;
            end

            // Stall the result side long enough to back up the byte input
            if (phase == 1) hold_armed = 1'b1;

            // Change the header while a frame is half collected
            if (phase == 2) begin
                send_byte(book.header);
                repeat (11) send_byte(8'($urandom_range(0, 255)));
                settle();
                write_reg(REG_HEADER, book.header ^ 8'($urandom_range(1, 255)));
                repeat (11) send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(book.footer);
            end

            for (int f = 0; f < 3; f++) begin
                pick = $urandom_range(0, 7);
                if (phase == 0 && f == 0) kind = FRAME_BAD_FOOTER;
                else if (pick == 0) kind = FRAME_BAD_FOOTER;
                else if (pick == 1 && gap_pct != 0) kind = FRAME_SHORT;
                else kind = FRAME_GOOD;
                send_noise($urandom_range(0, 2));
                send_frame(kind);
            end
            phase++;
        end

        // Drain and let the block go idle
        settle();

        $display("Covered %0d byte requests over %0d register settings, idle bursts, a long stall",
                 bytes_sent, settings_used);
        $display("and a header change mid-frame: %0d good, %0d bad frames, %0d results.",
                 book.good_frames, book.bad_frames, book.checked);
        if (book.errors == 0 && book.channel_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
